FILE: rtl/sukt_pkg.sv
// ----------------------------------------------------------------------------
// sukt_pkg: shared types and constants of the sorted unique-key table
// Holds the operation and status codes, the item widths and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sukt_pkg;

   // Widths of the item fields.
   localparam int GROUP_W    = 8;
   localparam int KEY_W      = 64;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;

   // Operation requested by an input item.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LIST   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   // Status carried by a result item.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_LISTED    = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   // Source of the payload of a result item.
   typedef enum logic {
      EMIT_CODE = 1'b0,
      EMIT_PEND = 1'b1
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         accept;
      logic         rd_issue;
      logic         scan_eval;
      logic         shift_init;
      logic         shift_rd;
      logic         shift_wr;
      logic         write_new;
      logic         clear;
      logic         list_eval;
      logic         emit;
      emit_sel_type emit_sel;
      status_type   emit_status;
      logic         emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   idx_end;
      logic   dup;
      logic   full;
      logic   at_pos;
      logic   rd_match;
      logic   pend_valid;
      logic   out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/sorted_unique_key_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table: table of (group, name) entries kept in sorted order
// An item on the req_ channel asks to insert an entry, list one group or clear
// the table; the block answers on the rsp_ channel. Insert and clear give one
// result item; a list gives one item per entry of the group, tlast on the
// final one, or a single group-empty item. An insert whose name is already
// present in any group is refused, as is one into a full table.
// One item is handled at a time: req_tready is high only while idle.
// An unused opcode gives no result item. The final result item turns valid
// on the same edge at which the block returns to idle.
// The entry memory has a single read port: each stored entry is read once
// per scan and once more per shift step.
// Reset empties the table at once; no clearing pass is needed. When the
// receiver holds rsp_tready low, the finished item waits in the output
// register and the block stalls at its next result item only.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_key_table #(
   parameter int CAPACITY   = 16,
   parameter int NAME_BYTES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: name_key (64), group_id (8).
   input  wire logic [sukt_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: opcode (2).
   input  wire logic [sukt_pkg::OP_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // Fields from bit 0: out_name (64), out_group (8).
   output logic [sukt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Fields from bit 0: status (3).
   output logic [sukt_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic                                 rsp_tlast
);

   sukt_pkg::cmd_type cmd;
   sukt_pkg::sts_type sts;

   // Sequencing of every request.
   sukt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Entry memory, counters and output register.
   sukt_dp #(
      .CAPACITY   (CAPACITY),
      .NAME_BYTES (NAME_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/sukt_dp.sv
// ----------------------------------------------------------------------------
// sukt_dp: datapath of the sorted unique-key table
// Holds the entry memory, the entry count, the scan index, the insert
// position, the pending listed entry and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_dp #(
   parameter int CAPACITY   = 16,
   parameter int NAME_BYTES = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sukt_pkg::cmd_type                cmd,
   output sukt_pkg::sts_type                     sts,
   input  wire logic [sukt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [sukt_pkg::OP_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [sukt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [sukt_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int NAME_W  = 8 * NAME_BYTES;
   localparam int ENTRY_W = sukt_pkg::GROUP_W + NAME_W;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Entry memory, each entry {group, name} so that one compare orders it.
   logic [ENTRY_W-1:0] mem [CAPACITY];

   logic [ENTRY_W-1:0]               rd_data_ff;
   logic [sukt_pkg::OP_W-1:0]        op_ff;
   logic [NAME_W-1:0]                key_ff;
   logic [sukt_pkg::GROUP_W-1:0]     grp_ff;
   logic [CNT_W-1:0]                 count_ff;
   logic [CNT_W-1:0]                 count_in;
   logic [CNT_W-1:0]                 idx_ff;
   logic [CNT_W-1:0]                 idx_in;
   logic [CNT_W-1:0]                 idx_dec;
   logic [CNT_W-1:0]                 pos_ff;
   logic                             dup_ff;
   logic                             pend_valid_ff;
   logic [NAME_W-1:0]                pend_name_ff;
   logic [sukt_pkg::GROUP_W-1:0]     pend_grp_ff;
   logic                             rsp_tvalid_ff;
   logic [sukt_pkg::RSP_DATA_W-1:0]  rsp_tdata_ff;
   logic [sukt_pkg::RSP_DATA_W-1:0]  rsp_tdata_in;
   logic [sukt_pkg::STATUS_W-1:0]    rsp_tuser_ff;
   logic                             rsp_tlast_ff;
   logic                             out_free;

   logic [sukt_pkg::GROUP_W-1:0]     rd_grp;
   logic [NAME_W-1:0]                rd_name;
   logic                             sorts_before;
   logic [IDX_W-1:0]                 rd_addr;
   logic [IDX_W-1:0]                 wr_addr;
   logic [ENTRY_W-1:0]               wr_data;
   logic                             wr_en;

   assign rd_grp       = rd_data_ff[ENTRY_W-1 -: sukt_pkg::GROUP_W];
   assign rd_name      = rd_data_ff[NAME_W-1:0];
   assign sorts_before = rd_data_ff < {grp_ff, key_ff};
   assign idx_dec      = idx_ff - 1'b1;
   assign out_free     = !rsp_tvalid_ff || rsp_tready;

   // Memory ports: one read with registered data, one write.
   assign rd_addr = cmd.shift_rd ? idx_dec[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_en   = cmd.write_new || cmd.shift_wr;
   assign wr_addr = cmd.write_new ? pos_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.write_new ? {grp_ff, key_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue || cmd.shift_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.write_new) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Next scan index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.shift_init) begin
         idx_in = count_ff;
      end else if (cmd.shift_wr) begin
         idx_in = idx_dec;
      end else if (cmd.scan_eval || cmd.list_eval) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Payload of the next result item.
   always_comb begin
      rsp_tdata_in = '0;
      if (cmd.emit_sel == sukt_pkg::EMIT_PEND) begin
         rsp_tdata_in = {pend_grp_ff, sukt_pkg::KEY_W'(pend_name_ff)};
      end
   end

   // Control state: count, scan state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         pos_ff        <= '0;
         dup_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.accept) begin
            pos_ff        <= '0;
            dup_ff        <= 1'b0;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan_eval) begin
            if (rd_name == key_ff) begin
               dup_ff <= 1'b1;
            end
            if (sorts_before) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end else if (cmd.list_eval && (rd_grp == grp_ff)) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request fields, pending entry and result item.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tuser;
         key_ff <= req_tdata[NAME_W-1:0];
         grp_ff <= req_tdata[sukt_pkg::KEY_W +: sukt_pkg::GROUP_W];
      end
      if (cmd.list_eval && (rd_grp == grp_ff)) begin
         pend_name_ff <= rd_name;
         pend_grp_ff  <= rd_grp;
      end
      if (cmd.emit) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= cmd.emit_status;
         rsp_tlast_ff <= cmd.emit_last;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.op         = sukt_pkg::op_type'(op_ff);
      sts.idx_end    = idx_ff == count_ff;
      sts.dup        = dup_ff;
      sts.full       = count_ff == CNT_W'(CAPACITY);
      sts.at_pos     = idx_ff == pos_ff;
      sts.rd_match   = rd_grp == grp_ff;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

FILE: rtl/sukt_ctrl.sv
// ----------------------------------------------------------------------------
// sukt_ctrl: controller of the sorted unique-key table
// Sequences the duplicate scan, the shift and write of an insert, the walk of
// a list request and the result items through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output sukt_pkg::cmd_type      cmd,
   input  wire sukt_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_DECIDE,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_LIST_RD,
      S_LIST_EVAL,
      S_LIST_END,
      S_RESPOND
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   sukt_pkg::status_type code_ff;
   sukt_pkg::status_type code_in;

   assign req_tready = state_ff == S_IDLE;

   // Next state, result code and datapath commands.
   always_comb begin
      state_in        = state_ff;
      code_in         = code_ff;
      cmd             = '0;
      cmd.emit_sel    = sukt_pkg::EMIT_CODE;
      cmd.emit_status = code_ff;
      cmd.emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               sukt_pkg::OP_INSERT: state_in = S_SCAN_RD;
               sukt_pkg::OP_LIST:   state_in = S_LIST_RD;
               sukt_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  code_in   = sukt_pkg::ST_CLEARED;
                  state_in  = S_RESPOND;
               end
               default: state_in = S_IDLE;
            endcase
         end
         // Walk the table for a duplicate name and the insert position.
         S_SCAN_RD: begin
            if (sts.idx_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_SCAN_EVAL;
            end
         end
         S_SCAN_EVAL: begin
            cmd.scan_eval = 1'b1;
            state_in      = S_SCAN_RD;
         end
         // A duplicate wins over a full table.
         S_DECIDE: begin
            if (sts.dup) begin
               code_in  = sukt_pkg::ST_DUPLICATE;
               state_in = S_RESPOND;
            end else if (sts.full) begin
               code_in  = sukt_pkg::ST_FULL;
               state_in = S_RESPOND;
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT_CHK;
            end
         end
         // Move entries up one place from the top down to the insert position.
         S_SHIFT_CHK: begin
            if (sts.at_pos) begin
               cmd.write_new = 1'b1;
               code_in       = sukt_pkg::ST_INSERTED;
               state_in      = S_RESPOND;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_CHK;
         end
         // List walk: a matching entry is held back until the next match or
         // the end of the table tells whether it is the final one.
         S_LIST_RD: begin
            if (sts.idx_end) begin
               state_in = S_LIST_END;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_LIST_EVAL;
            end
         end
         S_LIST_EVAL: begin
            if (sts.rd_match && sts.pend_valid) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = sukt_pkg::EMIT_PEND;
                  cmd.emit_status = sukt_pkg::ST_LISTED;
                  cmd.emit_last   = 1'b0;
                  cmd.list_eval   = 1'b1;
                  state_in        = S_LIST_RD;
               end
            end else begin
               cmd.list_eval = 1'b1;
               state_in      = S_LIST_RD;
            end
         end
         S_LIST_END: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.pend_valid) begin
                  cmd.emit_sel    = sukt_pkg::EMIT_PEND;
                  cmd.emit_status = sukt_pkg::ST_LISTED;
               end else begin
                  cmd.emit_status = sukt_pkg::ST_EMPTY;
               end
               state_in = S_IDLE;
            end
         end
         S_RESPOND: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and result code registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= sukt_pkg::ST_INSERTED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

`default_nettype wire
